@@ hdl/rct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table package
// Field widths, operation and status codes shared by the table RTL.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int unsigned FIELD_W = 48;  // width of an address field on the ports
  localparam int unsigned CNT_W   = 32;  // width of a reference count

  typedef enum logic {
    FUNC_TRACK  = 1'b0,
    FUNC_ASSIGN = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_NULL = 2'd3
  } status_e;

endpackage
`default_nettype wire

@@ hdl/reference_count_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table
// Bounded table of tracked block addresses, each with a reference count.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its valid store, one entry a cycle, so
// busy stays high until the sweep ends; no word is taken before that.
// A word is taken on a clock edge with start high and busy low. A track
// of a null address answers in the next cycle. Every other word walks the
// whole table through one read port of the entry memory, one entry a cycle,
// matching the acquire and, for an assign, the release address in the
// same pass; a track then goes on through S_TAIL and S_TRACK_WR, an
// assign through S_TAIL, S_ACQ_WR and S_REL_WR. The result is shown
// for exactly one cycle, marked by done_o, and the receiver cannot stall
// it: capture it on that cycle. busy is low again while done_o is high,
// so the next word may be started then.
// ----------------------------------------------------------------------------
module reference_count_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_WIDTH  = 48
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire                              func_i,
  input  wire  [rct_pkg::FIELD_W-1:0]      new_addr_i,
  input  wire  [rct_pkg::FIELD_W-1:0]      release_addr_i,
  input  wire  [rct_pkg::FIELD_W-1:0]      acquire_addr_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [rct_pkg::FIELD_W-1:0]      returned_addr_o,
  output logic                             acquire_hit_o,
  output logic                             release_hit_o,
  output logic                             release_done_o,
  output logic [rct_pkg::CNT_W-1:0]        remaining_count_o
);

  // Address bits that survive the mask: never more than the port carries.
  localparam int unsigned KeyW  = (ADDR_WIDTH < rct_pkg::FIELD_W) ? ADDR_WIDTH
                                                                   : rct_pkg::FIELD_W;
  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned OccW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW  = rct_pkg::CNT_W + KeyW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_TRACK_WR,
    S_ACQ_WR,
    S_REL_WR
  } state_e;

  state_e state_q;

  // Sequencer registers
  logic [IdxW-1:0]          scan_ptr_q;
  logic                     cmp_pend_q;
  logic [IdxW-1:0]          cmp_idx_q;
  logic [OccW-1:0]          occ_q;
  rct_pkg::func_e           func_q;
  logic [KeyW-1:0]          key_a_q;   // acquire address, or the address to track
  logic [KeyW-1:0]          key_r_q;   // release address
  logic                     acq_hit_q;
  logic [IdxW-1:0]          acq_idx_q;
  logic [rct_pkg::CNT_W-1:0] acq_cnt_q;
  logic                     rel_hit_q;
  logic [IdxW-1:0]          rel_idx_q;
  logic [rct_pkg::CNT_W-1:0] rel_cnt_q;
  logic                     free_hit_q;
  logic [IdxW-1:0]          free_idx_q;

  // Memories and their registered read data
  logic                     valid_mem [TABLE_DEPTH];
  logic [EntW-1:0]          entry_mem [TABLE_DEPTH];
  logic                     vld_rd_q;
  logic [EntW-1:0]          ent_rd_q;

  logic                     vmem_we;
  logic [IdxW-1:0]          vmem_waddr;
  logic                     vmem_wdata;
  logic                     emem_we;
  logic [IdxW-1:0]          emem_waddr;
  logic [EntW-1:0]          emem_wdata;

  // Shared count arithmetic
  logic [rct_pkg::CNT_W-1:0] acq_inc;
  logic [rct_pkg::CNT_W-1:0] rel_base;
  logic [rct_pkg::CNT_W-1:0] rel_dec;
  logic                      rel_zero;
  logic                      track_ok;

  // Compare stage on the word just read
  logic [KeyW-1:0]           rd_key;
  logic [rct_pkg::CNT_W-1:0] rd_cnt;
  logic                      acq_match;
  logic                      rel_match;
  logic                      free_match;

  logic [KeyW-1:0]           in_new_key;
  logic [KeyW-1:0]           in_acq_key;
  logic [KeyW-1:0]           in_rel_key;

  assign in_new_key = new_addr_i[KeyW-1:0];
  assign in_acq_key = acquire_addr_i[KeyW-1:0];
  assign in_rel_key = release_addr_i[KeyW-1:0];

  assign rd_key = ent_rd_q[KeyW-1:0];
  assign rd_cnt = ent_rd_q[EntW-1:KeyW];

  // Addresses are unique in the table, so the first match is the only one.
  assign acq_match  = cmp_pend_q && vld_rd_q && !acq_hit_q && (key_a_q != '0)
                      && (rd_key == key_a_q);
  assign rel_match  = cmp_pend_q && vld_rd_q && !rel_hit_q
                      && (func_q == rct_pkg::FUNC_ASSIGN) && (key_r_q != '0)
                      && (rd_key == key_r_q);
  assign free_match = cmp_pend_q && !vld_rd_q && !free_hit_q;

  // Saturating increment, then decrement; a shared entry sees the increment first.
  assign acq_inc  = (acq_cnt_q == '1) ? acq_cnt_q : acq_cnt_q + 1'b1;
  assign rel_base = (acq_hit_q && (acq_idx_q == rel_idx_q)) ? acq_inc : rel_cnt_q;
  assign rel_dec  = (rel_base == '0) ? '0 : rel_base - 1'b1;
  assign rel_zero = (rel_dec == '0);
  assign track_ok = !acq_hit_q && (occ_q != FullOcc);

  // Memory write steering
  always_comb begin
    vmem_we    = 1'b0;
    vmem_waddr = scan_ptr_q;
    vmem_wdata = 1'b0;
    emem_we    = 1'b0;
    emem_waddr = free_idx_q;
    emem_wdata = {rct_pkg::CNT_W'(1), key_a_q};
    case (state_q)
      S_CLEAR: begin
        vmem_we = 1'b1;
      end
      S_TRACK_WR: begin
        vmem_we    = track_ok;
        vmem_waddr = free_idx_q;
        vmem_wdata = 1'b1;
        emem_we    = track_ok;
      end
      S_ACQ_WR: begin
        emem_we    = acq_hit_q;
        emem_waddr = acq_idx_q;
        emem_wdata = {acq_inc, key_a_q};
      end
      S_REL_WR: begin
        vmem_we    = rel_hit_q && rel_zero;
        vmem_waddr = rel_idx_q;
        emem_we    = rel_hit_q && !rel_zero;
        emem_waddr = rel_idx_q;
        emem_wdata = {rel_dec, key_r_q};
      end
      default: begin
      end
    endcase
  end

  // Valid store: cleared by the sweep after reset
  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      valid_mem[vmem_waddr] <= vmem_wdata;
    end
    vld_rd_q <= valid_mem[scan_ptr_q];
  end

  // Entry store: address and count, used only where valid
  always_ff @(posedge clk_i) begin
    if (emem_we) begin
      entry_mem[emem_waddr] <= emem_wdata;
    end
    ent_rd_q <= entry_mem[scan_ptr_q];
  end

  // Sequencer, compare bookkeeping and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      scan_ptr_q        <= '0;
      cmp_pend_q        <= 1'b0;
      cmp_idx_q         <= '0;
      occ_q             <= '0;
      func_q            <= rct_pkg::FUNC_TRACK;
      key_a_q           <= '0;
      key_r_q           <= '0;
      acq_hit_q         <= 1'b0;
      acq_idx_q         <= '0;
      acq_cnt_q         <= '0;
      rel_hit_q         <= 1'b0;
      rel_idx_q         <= '0;
      rel_cnt_q         <= '0;
      free_hit_q        <= 1'b0;
      free_idx_q        <= '0;
      done_o            <= 1'b0;
      status_o          <= rct_pkg::ST_OK;
      returned_addr_o   <= '0;
      acquire_hit_o     <= 1'b0;
      release_hit_o     <= 1'b0;
      release_done_o    <= 1'b0;
      remaining_count_o <= '0;
    end else begin
      done_o <= 1'b0;

      // Record hits on the word read in the previous cycle
      if (acq_match) begin
        acq_hit_q <= 1'b1;
        acq_idx_q <= cmp_idx_q;
        acq_cnt_q <= rd_cnt;
      end
      if (rel_match) begin
        rel_hit_q <= 1'b1;
        rel_idx_q <= cmp_idx_q;
        rel_cnt_q <= rd_cnt;
      end
      if (free_match) begin
        free_hit_q <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end

      case (state_q)
        S_CLEAR: begin
          scan_ptr_q <= scan_ptr_q + 1'b1;
          if (scan_ptr_q == LastIdx) begin
            scan_ptr_q <= '0;
            state_q    <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            func_q     <= rct_pkg::func_e'(func_i);
            key_r_q    <= in_rel_key;
            acq_hit_q  <= 1'b0;
            rel_hit_q  <= 1'b0;
            free_hit_q <= 1'b0;
            scan_ptr_q <= '0;
            if (func_i == rct_pkg::FUNC_TRACK) begin
              key_a_q <= in_new_key;
            end else begin
              key_a_q <= in_acq_key;
            end
            if ((func_i == rct_pkg::FUNC_TRACK) && (in_new_key == '0)) begin
              // Null address: answer at once, table untouched
              done_o            <= 1'b1;
              status_o          <= rct_pkg::ST_NULL;
              returned_addr_o   <= '0;
              acquire_hit_o     <= 1'b0;
              release_hit_o     <= 1'b0;
              release_done_o    <= 1'b0;
              remaining_count_o <= '0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          cmp_pend_q <= 1'b1;
          cmp_idx_q  <= scan_ptr_q;
          scan_ptr_q <= scan_ptr_q + 1'b1;
          if (scan_ptr_q == LastIdx) begin
            scan_ptr_q <= '0;
            state_q    <= S_TAIL;
          end
        end

        S_TAIL: begin
          // Last compare happens this cycle
          cmp_pend_q <= 1'b0;
          if (func_q == rct_pkg::FUNC_TRACK) begin
            state_q <= S_TRACK_WR;
          end else begin
            state_q <= S_ACQ_WR;
          end
        end

        S_TRACK_WR: begin
          done_o            <= 1'b1;
          returned_addr_o   <= '0;
          acquire_hit_o     <= 1'b0;
          release_hit_o     <= 1'b0;
          release_done_o    <= 1'b0;
          remaining_count_o <= '0;
          if (acq_hit_q) begin
            status_o <= rct_pkg::ST_DUP;
          end else if (occ_q == FullOcc) begin
            status_o <= rct_pkg::ST_FULL;
          end else begin
            status_o <= rct_pkg::ST_OK;
            occ_q    <= occ_q + 1'b1;
          end
          state_q <= S_IDLE;
        end

        S_ACQ_WR: begin
          state_q <= S_REL_WR;
        end

        S_REL_WR: begin
          done_o          <= 1'b1;
          status_o        <= rct_pkg::ST_OK;
          returned_addr_o <= acq_hit_q ? rct_pkg::FIELD_W'(key_a_q) : '0;
          acquire_hit_o   <= acq_hit_q;
          release_hit_o   <= rel_hit_q;
          release_done_o  <= rel_hit_q && rel_zero;
          remaining_count_o <= (rel_hit_q && !rel_zero) ? rel_dec : '0;
          if (rel_hit_q && rel_zero && (occ_q != '0)) begin
            occ_q <= occ_q - 1'b1;
          end
          state_q <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  // A result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while sequencer busy");

  // Freeing an entry implies it was found and has nothing left
  a_release_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && release_done_o) |-> (release_hit_o && (remaining_count_o == '0)))
    else $error("release done without a hit or with a count left");

  // No returned address without an acquire hit
  a_returned_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !acquire_hit_o) |-> (returned_addr_o == '0))
    else $error("returned address without acquire hit");

  // Occupancy never passes the table depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullOcc)
    else $error("occupancy beyond table depth");
`endif

endmodule
`default_nettype wire
